[design/i2cms_pkg.sv]
// Shared types and constants for the I2C master bit sequencer.
`default_nettype none

package i2cms_pkg;

    typedef logic [2:0] kind_t;

    // Input kind codes.
    localparam kind_t KIND_TICK   = 3'd0;
    localparam kind_t KIND_START  = 3'd1;
    localparam kind_t KIND_STOP   = 3'd2;
    localparam kind_t KIND_WRITE  = 3'd3;
    localparam kind_t KIND_RDACK  = 3'd4;
    localparam kind_t KIND_RDNACK = 3'd5;

    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
    localparam int         QUEUE_DEPTH       = 2;

    // One classified pin step as it travels from the front to the back.
    typedef struct packed {
        kind_t      cmd;        // command code, or tick for anything else
        logic [7:0] data_byte;
        logic       sda_in;
    } item_t;

    // One result of a pin step.
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive_enable;
        logic       busy_res;
        logic       done_res;
        logic       ack_failed;
        logic [7:0] read_byte;
    } result_t;

endpackage

`default_nettype wire

[design/i2cms_channels.sv]
// Valid/ready channel interfaces for the input steps and the results.
`default_nettype none

interface i2cms_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       sda_in;

    modport source (output valid, output kind, output data_byte, output sda_in, input ready);
    modport sink   (input valid, input kind, input data_byte, input sda_in, output ready);
endinterface

interface i2cms_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic       ack_failed;
    logic [7:0] read_byte;

    modport source (output valid, output scl_level, output sda_level, output sda_drive_enable,
                    output busy_res, output done_res, output ack_failed, output read_byte,
                    input ready);
    modport sink   (input valid, input scl_level, input sda_level, input sda_drive_enable,
                    input busy_res, input done_res, input ack_failed, input read_byte,
                    output ready);
endinterface

`default_nettype wire

[design/i2cms_front.sv]
// Front end: takes input transfers and classifies the kind code.
`default_nettype none

module i2cms_front (
    i2cms_in_if.sink         in_ch,
    output logic             push_valid,
    input  logic             push_ready,
    output i2cms_pkg::item_t push_item
);
    import i2cms_pkg::*;

    kind_t cmd;

    // Unused kind codes behave as a tick.
    always_comb
    begin
        if (in_ch.kind inside {[KIND_START:KIND_RDNACK]})
        begin
            cmd = in_ch.kind;
        end
        else
        begin
            cmd = KIND_TICK;
        end
    end

    assign push_valid          = in_ch.valid;
    assign in_ch.ready         = push_ready;
    assign push_item.cmd       = cmd;
    assign push_item.data_byte = in_ch.data_byte;
    assign push_item.sda_in    = in_ch.sda_in;

endmodule

`default_nettype wire

[design/i2cms_queue.sv]
// Short FIFO of classified steps between the front and the back.
`default_nettype none

module i2cms_queue #(
    parameter int Depth = i2cms_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  i2cms_pkg::item_t push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output i2cms_pkg::item_t pop_item
);
    import i2cms_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    item_t            mem [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CntW'(Depth));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[design/i2cms_back.sv]
// Back end: line sequencer state machine and the registered result stage.
`default_nettype none

module i2cms_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  i2cms_pkg::item_t pop_item,
    i2cms_out_if.source      out_ch
);
    import i2cms_pkg::*;

    localparam logic [4:0] PH_IDLE  = 5'd0;
    localparam logic [4:0] PH_ST1   = 5'd1;
    localparam logic [4:0] PH_ST2   = 5'd2;
    localparam logic [4:0] PH_ST3   = 5'd3;
    localparam logic [4:0] PH_SP1   = 5'd4;
    localparam logic [4:0] PH_SP2   = 5'd5;
    localparam logic [4:0] PH_SP3   = 5'd6;
    localparam logic [4:0] PH_WSDA  = 5'd7;
    localparam logic [4:0] PH_WSCLH = 5'd8;
    localparam logic [4:0] PH_WSCLL = 5'd9;
    localparam logic [4:0] PH_WACK  = 5'd10;
    localparam logic [4:0] PH_WPOLL = 5'd11;
    localparam logic [4:0] PH_RSCLH = 5'd12;
    localparam logic [4:0] PH_RSCLL = 5'd13;
    localparam logic [4:0] PH_AK0   = 5'd14;
    localparam logic [4:0] PH_AK1   = 5'd15;
    localparam logic [4:0] PH_AK2   = 5'd16;
    localparam logic [4:0] PH_AK3   = 5'd17;

    logic [7:0] ack_timeout_reg;
    logic [4:0] phase_reg,    phase_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [3:0] bit_count_inc;
    logic [7:0] shift_reg,    shift_next;
    logic [7:0] poll_count_reg, poll_count_next;
    logic       scl_reg,      scl_next;
    logic       sda_reg,      sda_next;
    logic       sda_oe_reg,   sda_oe_next;
    kind_t      command_reg,  command_next;
    logic       done, failed;
    logic [7:0] rbyte;
    logic       take;
    logic       out_valid_reg;
    result_t    result_reg,   result_next;

    // A step is taken whenever the result stage is empty or being emptied.
    assign pop_ready     = !out_valid_reg || out_ch.ready;
    assign take          = pop_valid && pop_ready;
    assign bit_count_inc = bit_count_reg + 1'b1;

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        poll_count_next = poll_count_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        sda_oe_next     = sda_oe_reg;
        command_next    = command_reg;
        done            = 1'b0;
        failed          = 1'b0;
        rbyte           = 8'd0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (pop_item.cmd != KIND_TICK)
                begin
                    command_next = pop_item.cmd;
                    case (pop_item.cmd)
                        KIND_START:
                        begin
                            sda_oe_next = 1'b1;
                            sda_next    = 1'b1;
                            phase_next  = PH_ST1;
                        end
                        KIND_STOP:
                        begin
                            sda_oe_next = 1'b1;
                            scl_next    = 1'b0;
                            phase_next  = PH_SP1;
                        end
                        KIND_WRITE:
                        begin
                            sda_oe_next    = 1'b1;
                            scl_next       = 1'b0;
                            shift_next     = pop_item.data_byte;
                            bit_count_next = 4'd0;
                            phase_next     = PH_WSDA;
                        end
                        default:
                        begin
                            sda_oe_next    = 1'b0;
                            scl_next       = 1'b0;
                            shift_next     = 8'd0;
                            bit_count_next = 4'd0;
                            phase_next     = PH_RSCLH;
                        end
                    endcase
                end
            end
            PH_ST1:
            begin
                scl_next   = 1'b1;
                phase_next = PH_ST2;
            end
            PH_ST2:
            begin
                sda_next   = 1'b0;
                phase_next = PH_ST3;
            end
            PH_ST3:
            begin
                scl_next   = 1'b0;
                phase_next = PH_IDLE;
                done       = 1'b1;
            end
            PH_SP1:
            begin
                sda_next   = 1'b0;
                phase_next = PH_SP2;
            end
            PH_SP2:
            begin
                scl_next   = 1'b1;
                phase_next = PH_SP3;
            end
            PH_SP3:
            begin
                sda_next   = 1'b1;
                phase_next = PH_IDLE;
                done       = 1'b1;
                // A stop that follows a write can only be the ack-timeout stop.
                failed     = (command_reg == KIND_WRITE);
            end
            PH_WSDA:
            begin
                sda_next   = shift_reg[7];
                shift_next = {shift_reg[6:0], 1'b0};
                phase_next = PH_WSCLH;
            end
            PH_WSCLH:
            begin
                scl_next   = 1'b1;
                phase_next = PH_WSCLL;
            end
            PH_WSCLL:
            begin
                scl_next       = 1'b0;
                bit_count_next = bit_count_inc;
                phase_next     = (bit_count_inc >= 4'd8) ? PH_WACK : PH_WSDA;
            end
            PH_WACK:
            begin
                sda_oe_next     = 1'b0;
                scl_next        = 1'b1;
                poll_count_next = 8'd0;
                phase_next      = PH_WPOLL;
            end
            PH_WPOLL:
            begin
                if (!pop_item.sda_in)
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                else if (poll_count_reg == ack_timeout_reg)
                begin
                    sda_oe_next = 1'b1;
                    scl_next    = 1'b0;
                    phase_next  = PH_SP1;
                end
                else
                begin
                    poll_count_next = poll_count_reg + 1'b1;
                end
            end
            PH_RSCLH:
            begin
                scl_next   = 1'b1;
                shift_next = {shift_reg[6:0], pop_item.sda_in};
                phase_next = PH_RSCLL;
            end
            PH_RSCLL:
            begin
                scl_next       = 1'b0;
                bit_count_next = bit_count_inc;
                phase_next     = (bit_count_inc >= 4'd8) ? PH_AK0 : PH_RSCLH;
            end
            PH_AK0:
            begin
                sda_oe_next = 1'b1;
                sda_next    = (command_reg == KIND_RDACK) ? 1'b0 : 1'b1;
                phase_next  = PH_AK1;
            end
            PH_AK1:
            begin
                scl_next   = 1'b0;
                phase_next = PH_AK2;
            end
            PH_AK2:
            begin
                scl_next   = 1'b1;
                phase_next = PH_AK3;
            end
            PH_AK3:
            begin
                scl_next   = 1'b0;
                phase_next = PH_IDLE;
                done       = 1'b1;
                rbyte      = shift_reg;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_next.scl_level        = scl_next;
        result_next.sda_level        = sda_next;
        result_next.sda_drive_enable = sda_oe_next;
        result_next.busy_res         = (phase_next != PH_IDLE);
        result_next.done_res         = done;
        result_next.ack_failed       = failed;
        result_next.read_byte        = rbyte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= 4'd0;
            shift_reg       <= 8'd0;
            poll_count_reg  <= 8'd0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            sda_oe_reg      <= 1'b1;
            command_reg     <= KIND_TICK;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ack_timeout_reg <= cfg_wdata;
            end
            if (take)
            begin
                phase_reg      <= phase_next;
                bit_count_reg  <= bit_count_next;
                shift_reg      <= shift_next;
                poll_count_reg <= poll_count_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                sda_oe_reg     <= sda_oe_next;
                command_reg    <= command_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.scl_level        = result_reg.scl_level;
    assign out_ch.sda_level        = result_reg.sda_level;
    assign out_ch.sda_drive_enable = result_reg.sda_drive_enable;
    assign out_ch.busy_res         = result_reg.busy_res;
    assign out_ch.done_res         = result_reg.done_res;
    assign out_ch.ack_failed       = result_reg.ack_failed;
    assign out_ch.read_byte        = result_reg.read_byte;

endmodule

`default_nettype wire

[design/i2c_master_bit_sequencer_unit.sv]
// Top level of the I2C master bit sequencer: front end, step queue and sequencer back end.
//
//   Channel   Direction  Handshake      Payload
//   in_ch     sink       valid/ready    kind, data_byte, sda_in (one pin step)
//   out_ch    source     valid/ready    scl_level, sda_level, sda_drive_enable,
//                                       busy_res, done_res, ack_failed, read_byte
//   cfg       write      cfg_we         cfg_wdata -> ack_timeout
//
// Every accepted pin step yields exactly one result transfer. The sequencer
// retires one step per clock while out_ch does not stall, so the sustained
// rate is one transfer per cycle; a step passes through the queue memory and
// then the result register on its way to out_ch.
// Reset is asynchronous and active low; there is no clearing pass, the block
// takes a step in the first cycle after reset.
// When out_ch stalls, the result register holds and the queue absorbs up to
// QueueDepth further steps before in_ch.ready drops.
`default_nettype none

module i2c_master_bit_sequencer_unit #(
    parameter int QueueDepth = i2cms_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    i2cms_in_if.sink    in_ch,
    i2cms_out_if.source out_ch,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import i2cms_pkg::*;

    // Classified steps leave the front as transfers into the queue.
    logic  push_valid;
    logic  push_ready;
    item_t push_item;

    // The back end pops one step whenever its result register can take it.
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    i2cms_front u_front (
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    i2cms_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // The back end owns the ack timeout register and all line state.
    i2cms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

[tb/i2c_master_bit_sequencer_unit_tb.sv]
// Self-checking testbench for the I2C master bit sequencer unit.
`default_nettype none

module i2c_master_bit_sequencer_unit_tb;

    import i2cms_pkg::*;

    // A run that sees no transfer on either channel for this many cycles is hung.
    localparam int QUIET_LIMIT = 2000;
    // Extra cycles at the end, after every expected result has been transferred.
    localparam int TAIL_CYCLES = 8;
    // Ack delay that no timeout setting can tolerate, so the write gives up.
    localparam int NEVER_ACK = 300;
    // Rough number of pin steps for each of the four random phases.
    localparam int PHASE_STEPS = 130;
    localparam int MAX_REPORTS = 40;

    // Line sequencer phases as the predictor tracks them.
    typedef enum logic [4:0] {
        SEQ_IDLE,
        START_SCL_UP, START_SDA_DOWN, START_SCL_DOWN,
        STOP_SDA_DOWN, STOP_SCL_UP, STOP_SDA_UP,
        WR_DATA, WR_SCL_UP, WR_SCL_DOWN, WR_ACK_RELEASE, WR_ACK_POLL,
        RD_SCL_UP, RD_SCL_DOWN,
        RA_DRIVE, RA_SCL_LOW, RA_SCL_UP, RA_SCL_DOWN
    } seq_phase_e;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    i2cms_in_if  in_ch();
    i2cms_out_if out_ch();

    i2c_master_bit_sequencer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Predicted line state of the sequencer, advanced once per accepted step.
    seq_phase_e seq_phase;
    logic [3:0] bit_index;
    logic [7:0] shifter;
    logic [7:0] poll_index;
    logic       scl_q;
    logic       sda_q;
    logic       sda_oe_q;
    kind_t      active_cmd;
    logic [7:0] ack_limit;

    // Results still owed by the block, oldest first.
    result_t    expected_pins[$];
    result_t    last_result;
    int         steps_sent;
    int         error_count;

    // Idle and stall odds in percent, and odds in per mille of a full drain pause.
    int         send_idle_pct;
    int         stall_pct;
    int         pause_per_mille;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The predictor takes one pin step and returns the result it must cause.
    // Commands are taken only while the sequencer is idle; any other step is
    // a plain tick whose kind and data byte do not matter.
    function automatic result_t predict_pin_step(input kind_t k, input logic [7:0] d,
                                                 input logic s);
        result_t r;
        r = '0;
        case (seq_phase)
            SEQ_IDLE:
            begin
                if (k >= KIND_START && k <= KIND_RDNACK)
                begin
                    active_cmd = k;
                    if (k == KIND_START)
                    begin
                        sda_oe_q = 1'b1;
                        sda_q = 1'b1;
                        seq_phase = START_SCL_UP;
                    end
                    else if (k == KIND_STOP)
                    begin
                        sda_oe_q = 1'b1;
                        scl_q = 1'b0;
                        seq_phase = STOP_SDA_DOWN;
                    end
                    else if (k == KIND_WRITE)
                    begin
                        sda_oe_q = 1'b1;
                        scl_q = 1'b0;
                        shifter = d;
                        bit_index = '0;
                        seq_phase = WR_DATA;
                    end
                    else
                    begin
                        sda_oe_q = 1'b0;
                        scl_q = 1'b0;
                        shifter = '0;
                        bit_index = '0;
                        seq_phase = RD_SCL_UP;
                    end
                end
            end
            START_SCL_UP:   begin scl_q = 1'b1; seq_phase = START_SDA_DOWN; end
            START_SDA_DOWN: begin sda_q = 1'b0; seq_phase = START_SCL_DOWN; end
            START_SCL_DOWN:
            begin
                scl_q = 1'b0;
                seq_phase = SEQ_IDLE;
                r.done_res = 1'b1;
            end
            STOP_SDA_DOWN:  begin sda_q = 1'b0; seq_phase = STOP_SCL_UP; end
            STOP_SCL_UP:    begin scl_q = 1'b1; seq_phase = STOP_SDA_UP; end
            STOP_SDA_UP:
            begin
                // A stop that ends a write can only come from an ack timeout.
                sda_q = 1'b1;
                seq_phase = SEQ_IDLE;
                r.done_res = 1'b1;
                r.ack_failed = (active_cmd == KIND_WRITE);
            end
            WR_DATA:
            begin
                sda_q = shifter[7];
                shifter = {shifter[6:0], 1'b0};
                seq_phase = WR_SCL_UP;
            end
            WR_SCL_UP:      begin scl_q = 1'b1; seq_phase = WR_SCL_DOWN; end
            WR_SCL_DOWN:
            begin
                scl_q = 1'b0;
                bit_index = bit_index + 4'd1;
                seq_phase = (bit_index >= 4'd8) ? WR_ACK_RELEASE : WR_DATA;
            end
            WR_ACK_RELEASE:
            begin
                sda_oe_q = 1'b0;
                scl_q = 1'b1;
                poll_index = '0;
                seq_phase = WR_ACK_POLL;
            end
            WR_ACK_POLL:
            begin
                if (!s)
                begin
                    scl_q = 1'b0;
                    seq_phase = SEQ_IDLE;
                    r.done_res = 1'b1;
                end
                else if (poll_index == ack_limit)
                begin
                    sda_oe_q = 1'b1;
                    scl_q = 1'b0;
                    seq_phase = STOP_SDA_DOWN;
                end
                else
                    poll_index = poll_index + 8'd1;
            end
            RD_SCL_UP:
            begin
                scl_q = 1'b1;
                shifter = {shifter[6:0], s};
                seq_phase = RD_SCL_DOWN;
            end
            RD_SCL_DOWN:
            begin
                scl_q = 1'b0;
                bit_index = bit_index + 4'd1;
                seq_phase = (bit_index >= 4'd8) ? RA_DRIVE : RD_SCL_UP;
            end
            RA_DRIVE:
            begin
                sda_oe_q = 1'b1;
                sda_q = (active_cmd == KIND_RDACK) ? 1'b0 : 1'b1;
                seq_phase = RA_SCL_LOW;
            end
            RA_SCL_LOW:     begin scl_q = 1'b0; seq_phase = RA_SCL_UP; end
            RA_SCL_UP:      begin scl_q = 1'b1; seq_phase = RA_SCL_DOWN; end
            RA_SCL_DOWN:
            begin
                scl_q = 1'b0;
                seq_phase = SEQ_IDLE;
                r.done_res = 1'b1;
                r.read_byte = shifter;
            end
            default:        seq_phase = SEQ_IDLE;
        endcase
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.sda_drive_enable = sda_oe_q;
        r.busy_res = (seq_phase != SEQ_IDLE);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch in %s at %0t: got %h, expected %h", what, $time, got, want);
    endtask

    // Offers one pin step, possibly after a random gap, and waits for its transfer.
    // Valid stays high on return so that back-to-back steps need no extra edge;
    // whoever waits next lowers it.
    task automatic send_step(input kind_t k, input logic [7:0] d, input logic s);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= k;
        in_ch.data_byte <= d;
        in_ch.sda_in <= s;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        last_result = predict_pin_step(k, d, s);
        expected_pins.push_back(last_result);
        steps_sent++;
    endtask

    // Holds the sender back until every expected result has been transferred.
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_pins.size() != 0)
            @(posedge clk);
    endtask

    // The register is written only with nothing in flight.
    task automatic set_ack_timeout(input logic [7:0] v);
        wait_for_results();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        ack_limit = v;
    endtask

    // Issues one command and feeds steps until the sequence is over. During
    // the ack poll the slave holds SDA high for ack_delay samples and then
    // pulls it low. Elsewhere SDA is sda_fill, or random when sda_fill is 2.
    // Steps while busy carry random kinds, which the block must ignore.
    task automatic run_command(input kind_t k, input logic [7:0] d, input int ack_delay,
                               input int sda_fill, output logic failed);
        int   highs_left;
        logic s;
        highs_left = ack_delay;
        failed = 1'b0;
        send_step(k, d, 1'($urandom_range(1)));
        while (seq_phase != SEQ_IDLE)
        begin
            if ($urandom_range(999) < pause_per_mille)
                wait_for_results();
            if (seq_phase == WR_ACK_POLL)
            begin
                s = (highs_left > 0);
                if (highs_left > 0)
                    highs_left--;
            end
            else if (sda_fill == 2)
                s = 1'($urandom_range(1));
            else
                s = 1'(sda_fill);
            send_step(kind_t'($urandom_range(7)), 8'($urandom), s);
            if (last_result.ack_failed)
                failed = 1'b1;
        end
    endtask

    // Mostly quick acks; now and then no ack at all, and with a short timeout
    // an ack on the last poll that is still tolerated.
    function automatic int pick_ack_delay();
        int r;
        r = $urandom_range(99);
        if (r < ((ack_limit > 8'd20) ? 2 : 15))
            return NEVER_ACK;
        if (r < 25 && ack_limit <= 8'd20)
            return int'(ack_limit);
        return $urandom_range(3);
    endfunction

    // One random bus transaction: start, address, data bytes, stop. About one
    // in five is a lone command of any kind instead, as line noise.
    task automatic random_transaction();
        logic [7:0] addr;
        logic       failed;
        int         n;
        if ($urandom_range(99) < 20)
        begin
            run_command(kind_t'($urandom_range(7)), 8'($urandom), pick_ack_delay(), 2,
                        failed);
            return;
        end
        addr = 8'($urandom);
        run_command(KIND_START, 8'($urandom), 0, 2, failed);
        run_command(KIND_WRITE, addr, pick_ack_delay(), 2, failed);
        if (failed)
            return;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n && !failed; i++)
        begin
            if (addr[0])
                run_command((i == n - 1) ? KIND_RDNACK : KIND_RDACK, 8'($urandom), 0, 2,
                            failed);
            else
                run_command(KIND_WRITE, 8'($urandom), pick_ack_delay(), 2, failed);
        end
        if (!failed)
            run_command(KIND_STOP, 8'($urandom), 0, 2, failed);
    endtask

    // Steps while idle, including the unused kind codes, leave the lines alone.
    task automatic test_idle_steps();
        send_step(KIND_TICK, 8'h00, 1'b0);
        send_step(kind_t'(6), 8'hFF, 1'b1);
        send_step(kind_t'(7), 8'h5A, 1'b0);
    endtask

    task automatic test_start_stop();
        logic failed;
        run_command(KIND_START, 8'hFF, 0, 2, failed);
        run_command(KIND_STOP, 8'h00, 0, 2, failed);
    endtask

    // Data byte extremes with the longest timeout.
    task automatic test_write_bytes();
        logic failed;
        set_ack_timeout(8'd255);
        run_command(KIND_WRITE, 8'hFF, 0, 2, failed);
        run_command(KIND_WRITE, 8'h00, 5, 2, failed);
    endtask

    // An ack on the last tolerated poll passes; one poll later the write gives
    // up and sends a stop. A zero timeout tolerates no high sample at all.
    task automatic test_ack_timeout();
        logic failed;
        set_ack_timeout(8'd2);
        run_command(KIND_WRITE, 8'hA5, 2, 2, failed);
        run_command(KIND_WRITE, 8'h5A, 3, 2, failed);
        set_ack_timeout(8'd0);
        run_command(KIND_WRITE, 8'h81, 0, 2, failed);
        run_command(KIND_WRITE, 8'h7E, 1, 2, failed);
    endtask

    // Reads of all ones with ack and all zeros with nack.
    task automatic test_reads();
        logic failed;
        run_command(KIND_RDACK, 8'h00, 0, 1, failed);
        run_command(KIND_RDNACK, 8'hFF, 0, 0, failed);
    endtask

    // The sender stops before every step after the read command until the
    // block has delivered all that it owes.
    task automatic test_pause_for_drain();
        logic failed;
        pause_per_mille = 1000;
        run_command(KIND_RDACK, 8'h3C, 0, 2, failed);
        pause_per_mille = 5;
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall,
                                     input logic [7:0] timeout);
        int target;
        set_ack_timeout(timeout);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        target = steps_sent + PHASE_STEPS;
        while (steps_sent < target)
            random_transaction();
    endtask

    // The receiver stalls at random under the odds of the current phase.
    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= stall_pct);

    // Every result transfer must match the oldest expectation field by field.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_pins.size() == 0)
                report_mismatch("result with nothing expected", out_ch.read_byte, 8'h00);
            else
            begin
                want = expected_pins.pop_front();
                if (out_ch.scl_level !== want.scl_level)
                    report_mismatch("scl_level", 8'(out_ch.scl_level), 8'(want.scl_level));
                if (out_ch.sda_level !== want.sda_level)
                    report_mismatch("sda_level", 8'(out_ch.sda_level), 8'(want.sda_level));
                if (out_ch.sda_drive_enable !== want.sda_drive_enable)
                    report_mismatch("sda_drive_enable", 8'(out_ch.sda_drive_enable),
                                    8'(want.sda_drive_enable));
                if (out_ch.busy_res !== want.busy_res)
                    report_mismatch("busy_res", 8'(out_ch.busy_res), 8'(want.busy_res));
                if (out_ch.done_res !== want.done_res)
                    report_mismatch("done_res", 8'(out_ch.done_res), 8'(want.done_res));
                if (out_ch.ack_failed !== want.ack_failed)
                    report_mismatch("ack_failed", 8'(out_ch.ack_failed), 8'(want.ack_failed));
                if (out_ch.read_byte !== want.read_byte)
                    report_mismatch("read_byte", out_ch.read_byte, want.read_byte);
            end
        end
    end

    // The watchdog ends a run that has gone quiet on both channels.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        // Reset values of the predictor mirror those of the block.
        seq_phase = SEQ_IDLE;
        bit_index = '0;
        shifter = '0;
        poll_index = '0;
        scl_q = 1'b1;
        sda_q = 1'b1;
        sda_oe_q = 1'b1;
        active_cmd = KIND_TICK;
        ack_limit = ACK_TIMEOUT_RESET;
        steps_sent = 0;
        error_count = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        pause_per_mille = 5;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.kind <= KIND_TICK;
        in_ch.data_byte <= '0;
        in_ch.sda_in <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The directed part runs at full rate on both sides and starts out
        // from the reset value of the timeout.
        test_idle_steps();
        test_start_stop();
        test_reads();
        test_write_bytes();
        test_ack_timeout();
        test_pause_for_drain();

        // Random phases: no idling, sender gaps, receiver stalls, then both.
        test_random_phase(0, 0, 8'd250);
        test_random_phase(64, 0, 8'd255);
        test_random_phase(0, 64, 8'($urandom_range(0, 15)));
        test_random_phase(12, 12, 8'd1);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_pins.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
design/i2cms_pkg.sv
design/i2cms_channels.sv
design/i2cms_front.sv
design/i2cms_queue.sv
design/i2cms_back.sv
design/i2c_master_bit_sequencer_unit.sv
tb/i2c_master_bit_sequencer_unit_tb.sv
